### hdl/clnw_pkg.sv
// Shared types and constants for the character LCD nibble writer.
`default_nettype none
package clnw_pkg;

  // input modes
  localparam logic [1:0] MODE_CMD    = 2'd0;
  localparam logic [1:0] MODE_DATA   = 2'd1;
  localparam logic [1:0] MODE_NUMBER = 2'd2;
  localparam logic [1:0] MODE_BLANKS = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE_HIGH = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE_LOW  = 8'd1;

  localparam logic [7:0] ENABLE_HIGH_RST = 8'd5;
  localparam logic [7:0] ENABLE_LOW_RST  = 8'd10;

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_SPACE = 8'd32;

  // floor(v / 10) == (v * RECIP_10) >> RECIP_SHIFT for any 32-bit v
  localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
  localparam int unsigned RECIP_SHIFT = 35;

  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 8;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture the request
    logic conv_mul;   // divide-by-ten product
    logic conv_rem;   // store one digit, keep quotient
    logic pace_load;  // start strobe timer
    logic pace_run;   // timer counts
    logic advance;    // strobe taken, step to next nibble
  } clnw_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic item_empty;   // request gives no strobes
    logic item_number;  // request needs decimal conversion
    logic conv_last;    // current digit is the last one
    logic pace_done;    // strobe timer expired
    logic strobe_last;  // strobe on the bus ends the request
  } clnw_sts_t;

endpackage
`default_nettype wire

### hdl/clnw_ctrl.sv
// Sequencer for the nibble writer: request intake, conversion steps, pacing, output.
`default_nettype none
module clnw_ctrl (
  input  wire                clk,
  input  wire                rst,
  input  wire                s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  wire                m_tready,
  input  clnw_pkg::clnw_sts_t sts,
  output clnw_pkg::clnw_cmd_t cmd
);
  import clnw_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_REM  = 3'd2;
  localparam logic [2:0] ST_PACE = 3'd3;
  localparam logic [2:0] ST_SEND = 3'd4;

  logic [2:0] state, state_next;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_SEND);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load = 1'b1;
          if (sts.item_empty) begin
            state_next = ST_IDLE;
          end else if (sts.item_number) begin
            state_next = ST_MUL;
          end else begin
            cmd.pace_load = 1'b1;
            state_next    = ST_PACE;
          end
        end
      end
      ST_MUL: begin
        cmd.conv_mul = 1'b1;
        state_next   = ST_REM;
      end
      ST_REM: begin
        cmd.conv_rem = 1'b1;
        if (sts.conv_last) begin
          cmd.pace_load = 1'b1;
          state_next    = ST_PACE;
        end else begin
          state_next = ST_MUL;
        end
      end
      ST_PACE: begin
        cmd.pace_run = 1'b1;
        if (sts.pace_done) state_next = ST_SEND;
      end
      ST_SEND: begin
        if (m_tready) begin
          cmd.advance = 1'b1;
          if (sts.strobe_last) begin
            state_next = ST_IDLE;
          end else begin
            cmd.pace_load = 1'b1;
            state_next    = ST_PACE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

endmodule
`default_nettype wire

### hdl/clnw_datapath.sv
// Datapath: request registers, divide-by-ten digit unit, digit store, strobe timer.
`default_nettype none
module clnw_datapath #(
  parameter int unsigned MAX_DIGITS  = 10,
  parameter int unsigned MAX_BLANKS  = 32,
  parameter int unsigned CLKS_PER_MS = 1
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire  [1:0]          in_mode,
  input  wire  [31:0]         in_value,
  input  wire  [7:0]          enable_high_ms,
  input  wire  [7:0]          enable_low_ms,
  input  clnw_pkg::clnw_cmd_t cmd,
  output clnw_pkg::clnw_sts_t sts,
  output logic                reg_select,
  output logic [3:0]          nibble,
  output logic                last
);
  import clnw_pkg::*;

  localparam int unsigned MAX_BYTES = (MAX_BLANKS > MAX_DIGITS) ? MAX_BLANKS : MAX_DIGITS;
  localparam int unsigned RB_W  = $clog2(MAX_BYTES + 1);
  localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int unsigned IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int unsigned PRE_W = (CLKS_PER_MS > 1) ? $clog2(CLKS_PER_MS) : 1;
  localparam int unsigned Q_W   = 32 - 3;

  logic [1:0]       mode_q;
  logic [31:0]      val_q;
  logic [Q_W-1:0]   quot_q;
  logic [3:0]       dig_buf [MAX_DIGITS];
  logic [CNT_W-1:0] dig_cnt;
  logic [RB_W-1:0]  rem_bytes;
  logic             nib_hi;
  logic [8:0]       pace_ms;
  logic [PRE_W-1:0] pre_cnt;

  logic [63:0]      prod;
  logic [3:0]       q10_lo;
  logic [3:0]       digit;
  logic [RB_W-1:0]  rd_pos;
  logic [RB_W-1:0]  blank_cnt;
  logic [7:0]       byte_val;

  assign prod   = {32'd0, val_q} * {32'd0, RECIP_10};
  assign q10_lo = {quot_q[0], 3'b000} + {quot_q[2:0], 1'b0};
  assign digit  = val_q[3:0] - q10_lo;
  assign rd_pos = rem_bytes - RB_W'(1);

  assign blank_cnt = (in_value > 32'(MAX_BLANKS)) ? RB_W'(MAX_BLANKS) : in_value[RB_W-1:0];

  always_comb begin
    sts.item_empty  = (in_mode[1] && in_value[31]) ||
                      ((in_mode == MODE_BLANKS) && (in_value == 32'd0));
    sts.item_number = (in_mode == MODE_NUMBER);
    sts.conv_last   = (quot_q == '0) || (dig_cnt == CNT_W'(MAX_DIGITS - 1));
    sts.pace_done   = (pace_ms == 9'd0);
    sts.strobe_last = !nib_hi && (rem_bytes == RB_W'(1));
  end

  always_comb begin
    case (mode_q)
      MODE_CMD:    byte_val = val_q[7:0];
      MODE_DATA:   byte_val = val_q[7:0];
      MODE_NUMBER: byte_val = ASCII_ZERO + {4'd0, dig_buf[rd_pos[IDX_W-1:0]]};
      default:     byte_val = ASCII_SPACE;
    endcase
  end

  assign reg_select = (mode_q != MODE_CMD);
  assign nibble     = nib_hi ? byte_val[7:4] : byte_val[3:0];
  assign last       = sts.strobe_last;

  // request payload and conversion
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q <= in_mode;
      val_q  <= in_value;
      nib_hi <= 1'b1;
      case (in_mode)
        MODE_CMD:    rem_bytes <= RB_W'(1);
        MODE_DATA:   rem_bytes <= RB_W'(1);
        MODE_NUMBER: rem_bytes <= '0;
        default:     rem_bytes <= blank_cnt;
      endcase
    end else if (cmd.conv_mul) begin
      quot_q <= prod[RECIP_SHIFT +: Q_W];
    end else if (cmd.conv_rem) begin
      dig_buf[dig_cnt[IDX_W-1:0]] <= digit;
      val_q <= {3'b000, quot_q};
      if (sts.conv_last) rem_bytes <= RB_W'(dig_cnt) + RB_W'(1);
    end else if (cmd.advance) begin
      nib_hi <= !nib_hi;
      if (!nib_hi) rem_bytes <= rem_bytes - RB_W'(1);
    end
  end

  // digit count is architectural state with a reset value
  always_ff @(posedge clk) begin
    if (rst) begin
      dig_cnt <= '0;
    end else if (cmd.load && (in_mode == MODE_NUMBER) && !in_value[31]) begin
      dig_cnt <= '0;
    end else if (cmd.conv_rem) begin
      dig_cnt <= dig_cnt + CNT_W'(1);
    end
  end

  // strobe timer: enable high plus enable low, in ms ticks
  always_ff @(posedge clk) begin
    if (rst) begin
      pace_ms <= '0;
      pre_cnt <= '0;
    end else if (cmd.pace_load) begin
      pace_ms <= {1'b0, enable_high_ms} + {1'b0, enable_low_ms};
      pre_cnt <= '0;
    end else if (cmd.pace_run && (pace_ms != 9'd0)) begin
      if (pre_cnt == PRE_W'(CLKS_PER_MS - 1)) begin
        pre_cnt <= '0;
        pace_ms <= pace_ms - 9'd1;
      end else begin
        pre_cnt <= pre_cnt + PRE_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

### hdl/char_lcd_nibble_writer_unit.sv
// Top level of the character LCD 4-bit nibble writer.
// A byte request waits on the strobe timer (enable high plus enable low) before its first
// strobe; number requests first run a multiply and a remainder step per digit in the divider.
// Each strobe is paced by the timer and held until the sink takes it; one request in
// flight, up to 64 strobes, and a new request is accepted only after the final strobe.
// Reset (rst, synchronous): idle, timing registers 5 ms / 10 ms, digit count zero.
`default_nettype none
module char_lcd_nibble_writer_unit #(
  parameter int unsigned MAX_DIGITS  = 10,
  parameter int unsigned MAX_BLANKS  = 32,
  parameter int unsigned CLKS_PER_MS = 1
) (
  input  wire         clk,
  input  wire         rst,
  // request stream
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [clnw_pkg::IN_DATA_W-1:0] s_tdata,   // [31:0] value
  input  wire  [1:0]  s_tuser,                      // [1:0] mode
  // strobe stream
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [clnw_pkg::OUT_DATA_W-1:0] m_tdata,  // [3:0] nibble, rest zero
  output logic        m_tuser,                      // [0] reg_select
  output logic        m_tlast,                      // final strobe of the request
  // configuration write channel
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [clnw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire  [7:0]  cfg_data
);
  import clnw_pkg::*;

  logic [7:0] enable_high_ms;
  logic [7:0] enable_low_ms;
  clnw_cmd_t  cmd;
  clnw_sts_t  sts;
  logic       reg_select;
  logic [3:0] nibble;

  // config is always accepted; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_high_ms <= ENABLE_HIGH_RST;
      enable_low_ms  <= ENABLE_LOW_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ENABLE_HIGH: enable_high_ms <= cfg_data;
        REG_ENABLE_LOW:  enable_low_ms  <= cfg_data;
        default: ;
      endcase
    end
  end

  clnw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  clnw_datapath #(
    .MAX_DIGITS  (MAX_DIGITS),
    .MAX_BLANKS  (MAX_BLANKS),
    .CLKS_PER_MS (CLKS_PER_MS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .in_mode        (s_tuser),
    .in_value       (s_tdata),
    .enable_high_ms (enable_high_ms),
    .enable_low_ms  (enable_low_ms),
    .cmd            (cmd),
    .sts            (sts),
    .reg_select     (reg_select),
    .nibble         (nibble),
    .last           (m_tlast)
  );

  // strobe fields come straight from datapath registers, stable while waiting
  assign m_tdata = {4'b0000, nibble};
  assign m_tuser = reg_select;

endmodule
`default_nettype wire

### tb/clnw_strobe_checker.sv
`timescale 1ns / 100ps
// Strobe checker for the LCD nibble writer: predicts every strobe and compares it.
module clnw_strobe_checker #(
  parameter int NUM_DIGITS  = 10,
  parameter int BLANK_LIMIT = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [clnw_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic [1:0]                      s_tuser,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [clnw_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                            m_tuser,
  input  logic                            m_tlast,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [clnw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                      cfg_data,
  output int                              outstanding,
  output int                              mismatches
);
  import clnw_pkg::*;

  typedef struct packed {
    logic       reg_select;
    logic [3:0] nibble;
    logic       last;
  } strobe_t;

  strobe_t    expected_strobes[$];
  logic [3:0] digit_buf[NUM_DIGITS];
  logic [3:0] digit_cnt;
  logic [7:0] hold_high_ms;   // pin timing only, no effect on strobes
  logic [7:0] hold_low_ms;
  int         mismatch_total;

  initial begin
    outstanding    = 0;
    mismatches     = 0;
    mismatch_total = 0;
    digit_cnt      = '0;
    foreach (digit_buf[i]) digit_buf[i] = '0;
  end

  function automatic void push_byte(ref strobe_t burst[$], input logic rs,
                                    input logic [7:0] byte_val);
    burst.push_back('{reg_select: rs, nibble: byte_val[7:4], last: 1'b0});
    burst.push_back('{reg_select: rs, nibble: byte_val[3:0], last: 1'b0});
  endfunction

  task automatic predict_strobes(input logic [1:0] mode, input logic [31:0] value);
    strobe_t     burst[$];
    strobe_t     tail;
    logic [3:0]  lsd[NUM_DIGITS];
    logic [31:0] rest;
    int          n;
    int          blanks;
    case (mode)
      MODE_CMD:  push_byte(burst, 1'b0, value[7:0]);
      MODE_DATA: push_byte(burst, 1'b1, value[7:0]);
      MODE_NUMBER: begin
        // negative: no strobes, digit state untouched
        if (!value[31]) begin
          rest = value;
          n    = 0;
          // only the least significant NUM_DIGITS digits survive
          do begin
            lsd[n] = 4'(rest % 10);
            rest   = rest / 10;
            n++;
          end while (rest != 0 && n < NUM_DIGITS);
          for (int i = 0; i < n; i++) digit_buf[i] = lsd[n-1-i];
          digit_cnt = 4'(n);
          for (int i = 0; i < int'(digit_cnt); i++)
            push_byte(burst, 1'b1, ASCII_ZERO + 8'(digit_buf[i]));
        end
      end
      default: begin
        if (!value[31]) begin
          blanks = (value > BLANK_LIMIT) ? BLANK_LIMIT : int'(value);
          repeat (blanks) push_byte(burst, 1'b1, ASCII_SPACE);
        end
      end
    endcase
    if (burst.size() > 0) begin
      tail      = burst.pop_back();
      tail.last = 1'b1;
      burst.push_back(tail);
    end
    foreach (burst[i]) expected_strobes.push_back(burst[i]);
  endtask

  always @(posedge clk) begin : watch
    strobe_t seen;
    strobe_t want;
    if (rst) begin
      expected_strobes.delete();
      digit_cnt    = '0;
      hold_high_ms <= ENABLE_HIGH_RST;
      hold_low_ms  <= ENABLE_LOW_RST;
    end else begin
      // strobes first, so a strobe cannot match a request taken on the same edge
      if (m_tvalid && m_tready) begin
        seen = {m_tuser, m_tdata[3:0], m_tlast};
        if (expected_strobes.size() == 0) begin
          mismatch_total++;
          if (mismatch_total <= 10)
            $display("%0t: unexpected strobe rs=%0d nibble=%h last=%0d",
                     $realtime, seen.reg_select, seen.nibble, seen.last);
        end else begin
          want = expected_strobes.pop_front();
          if (seen !== want) begin
            mismatch_total++;
            if (mismatch_total <= 10)
              $display("%0t: mismatch exp rs=%0d nib=%h last=%0d, got rs=%0d nib=%h last=%0d",
                       $realtime, want.reg_select, want.nibble, want.last,
                       seen.reg_select, seen.nibble, seen.last);
          end
        end
      end
      if (s_tvalid && s_tready)
        predict_strobes(s_tuser, s_tdata);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ENABLE_HIGH: hold_high_ms <= cfg_data;
          REG_ENABLE_LOW:  hold_low_ms  <= cfg_data;
          default: ;   // unknown index, ignored
        endcase
      end
    end
    outstanding <= expected_strobes.size();
    mismatches  <= mismatch_total;
  end

endmodule

### tb/tb_char_lcd_nibble_writer_unit.sv
`timescale 1ns / 100ps
// Top of the LCD nibble writer testbench: clock, reset, requests, timing writes, verdict.
module tb_char_lcd_nibble_writer_unit;
  import clnw_pkg::*;

  // cycles to let the unit settle after the last strobe before timing is rewritten
  localparam int SETTLE_CYCLES = 64;

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;   // [31:0] value
  logic [1:0]            s_tuser   = '0;   // [1:0] mode
  logic                  m_tready  = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [7:0]            cfg_data  = '0;
  wire                   s_tready;
  wire                   m_tvalid;
  wire  [OUT_DATA_W-1:0] m_tdata;          // [3:0] nibble, rest zero
  wire                   m_tuser;          // [0] reg_select
  wire                   m_tlast;
  wire                   cfg_ready;
  int                    outstanding;
  int                    mismatches;

  // idle limits per phase; zero gives back-to-back stretches
  int gap_max   = 10;
  int stall_max = 10;

  char_lcd_nibble_writer_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  clnw_strobe_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop, set well beyond the slowest legal run of all phases.
  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Strobe side: random stall before every strobe, ready then held until taken.
  initial begin : strobe_sink
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = (stall_max > 0) ? $urandom_range(0, stall_max) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // One request: optional gap with valid low, then valid held until accepted.
  // Valid is only lowered on a gap, so back-to-back requests keep it high.
  task automatic send_request(input logic [1:0] mode, input logic [31:0] value);
    int gap;
    gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tuser  <= mode;
    do @(posedge clk); while (!s_tready);
  endtask

  // Mostly well-formed requests; numbers and blank counts are biased toward
  // short output, with negative and oversized values mixed in.
  task automatic send_random_request();
    logic [1:0]  mode;
    logic [31:0] value;
    int          pick;
    mode = 2'($urandom_range(0, 3));
    pick = $urandom_range(0, 9);
    case (mode)
      MODE_CMD, MODE_DATA: value = $urandom();
      MODE_NUMBER: begin
        if (pick == 0)      value = $urandom();                 // often negative
        else if (pick <= 3) value = $urandom_range(0, 99);
        else if (pick <= 6) value = $urandom_range(0, 99999);
        else                value = {1'b0, 31'($urandom())};     // up to ten digits
      end
      default: begin
        if (pick == 0)      value = $urandom();                 // negative or saturating
        else if (pick == 1) value = $urandom_range(30, 40);
        else                value = $urandom_range(0, 12);
      end
    endcase
    send_request(mode, value);
  endtask

  task automatic run_random(input int count);
    repeat (count) send_random_request();
  endtask

  // Idle the request side and wait until every predicted strobe has arrived.
  // The first wait lets the checker count the last accepted request.
  task automatic drain_requests();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Callers lower cfg_valid after their last write, never in the same step as a raise.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_timing(input logic [7:0] high_ms, input logic [7:0] low_ms);
    write_register(REG_ENABLE_HIGH, high_ms);
    write_register(REG_ENABLE_LOW, low_ms);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, reset timing (5 ms / 10 ms).
    // Byte modes: extremes, and upper value bits that must be ignored.
    send_request(MODE_CMD,  32'h0000_0000);
    send_request(MODE_CMD,  32'h5A5A_A5FF);
    send_request(MODE_CMD,  32'h0000_0028);
    send_request(MODE_DATA, 32'h0000_0041);
    send_request(MODE_DATA, 32'hFFFF_FF00);   // negative value still sends the byte
    send_request(MODE_DATA, 32'h0000_00FF);
    // Numbers: zero, single and two digits, longest values, negatives.
    send_request(MODE_NUMBER, 32'd0);
    send_request(MODE_NUMBER, 32'd9);
    send_request(MODE_NUMBER, 32'd10);
    send_request(MODE_NUMBER, 32'h7FFF_FFFF);
    send_request(MODE_NUMBER, 32'd1_000_000_000);
    send_request(MODE_NUMBER, 32'hFFFF_FFFF);
    send_request(MODE_NUMBER, 32'h8000_0000);
    send_request(MODE_NUMBER, 32'd42);        // digit state after the skipped negatives
    // Blanks: none, negative, one, limit, just over, saturating.
    send_request(MODE_BLANKS, 32'd0);
    send_request(MODE_BLANKS, 32'hFFFF_FFFF);
    send_request(MODE_BLANKS, 32'd1);
    send_request(MODE_BLANKS, 32'd32);
    send_request(MODE_BLANKS, 32'd33);
    send_request(MODE_BLANKS, 32'h7FFF_FFFF);
    drain_requests();

    // Fastest legal timing, random idling.
    set_timing(8'd1, 8'd1);
    run_random(40);
    drain_requests();

    // Random short timing, no idling on either side.
    gap_max   = 0;
    stall_max = 0;
    set_timing(8'($urandom_range(1, 6)), 8'($urandom_range(1, 6)));
    run_random(40);
    drain_requests();

    // Slowest legal timing, a handful of short requests.
    gap_max   = 10;
    stall_max = 10;
    set_timing(8'd255, 8'd255);
    send_request(MODE_CMD,    32'h0000_0001);
    send_request(MODE_DATA,   32'h0000_007E);
    send_request(MODE_NUMBER, 32'd5);
    send_request(MODE_BLANKS, 32'd1);
    drain_requests();

    // Zero timing values are kept as written; also writes to unknown indexes.
    write_register(REG_ENABLE_HIGH, 8'd0);
    write_register(REG_ENABLE_LOW, 8'd0);
    write_register(8'd2, 8'($urandom()));
    write_register(8'hFF, 8'($urandom()));
    cfg_valid <= 1'b0;
    run_random(5);
    drain_requests();

    // Random moderate timing, random idling.
    set_timing(8'($urandom_range(1, 8)), 8'($urandom_range(1, 8)));
    run_random(35);
    drain_requests();

    if (mismatches == 0 && outstanding == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
